>>> rtl/sha1sh_pkg.sv
// ----------------------------------------------------------------------------
// sha1sh_pkg
// Shared types and constants for the streaming SHA-1 hasher.
// ----------------------------------------------------------------------------
package sha1sh_pkg;

  localparam int WORD_W     = 32;
  localparam int NUM_CHAIN  = 5;
  localparam int BLOCK_W    = 512;
  localparam int ROUND_W    = 7;
  localparam int FILL_W     = 6;
  localparam int LEN_W      = 64;
  localparam int LEN_CNT_W  = 4;

  localparam logic [ROUND_W-1:0]   LAST_ROUND  = 7'd79;
  localparam logic [FILL_W-1:0]    FILL_FULL   = 6'd63;
  localparam logic [FILL_W-1:0]    FILL_LEN    = 6'd56;
  localparam logic [LEN_CNT_W-1:0] LEN_BYTES   = 4'd8;
  localparam logic [7:0]           PAD_MARK    = 8'h80;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [NUM_CHAIN-1:0][WORD_W-1:0] chain_t;

  localparam word_t IV0 = 32'h67452301;
  localparam word_t IV1 = 32'hEFCDAB89;
  localparam word_t IV2 = 32'h98BADCFE;
  localparam word_t IV3 = 32'h10325476;
  localparam word_t IV4 = 32'hC3D2E1F0;

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_DONE
  } state_t;

  // control from the sequencer to the datapath
  typedef struct packed {
    logic               shift_byte;
    logic [7:0]         byte_val;
    logic               load_work;
    logic               step;
    logic [ROUND_W-1:0] round;
    logic               add_chain;
    logic               init_chain;
  } ctl_t;

endpackage

>>> rtl/sha1sh_round.sv
// ----------------------------------------------------------------------------
// sha1sh_round
// One SHA-1 compression round: selects f and k by round number and forms
// the new working word.
// ----------------------------------------------------------------------------
module sha1sh_round (
  input  sha1sh_pkg::word_t               a,
  input  sha1sh_pkg::word_t               b,
  input  sha1sh_pkg::word_t               c,
  input  sha1sh_pkg::word_t               d,
  input  sha1sh_pkg::word_t               e,
  input  sha1sh_pkg::word_t               w,
  input  logic [sha1sh_pkg::ROUND_W-1:0]  round,
  output sha1sh_pkg::word_t               t
);
  import sha1sh_pkg::*;

  word_t f;
  word_t k;

  always_comb begin
    priority if (round < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (round < 7'd40) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (round < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
  end

  assign t = {a[26:0], a[31:27]} + f + e + k + w;

endmodule

>>> rtl/sha1sh_core.sv
// ----------------------------------------------------------------------------
// sha1sh_core
// Datapath: block buffer doubling as rolling message schedule, working
// registers a..e and the five chaining words.
// ----------------------------------------------------------------------------
module sha1sh_core (
  input  logic                clk,
  input  logic                rst_n,
  input  sha1sh_pkg::ctl_t    ctl,
  output sha1sh_pkg::chain_t  chain
);
  import sha1sh_pkg::*;

  logic [BLOCK_W-1:0] blk_r;
  word_t a_r, b_r, c_r, d_r, e_r;
  chain_t h_r;

  word_t w0, w2, w8, w13, w_mix, w_new, t;

  // word i of the schedule window sits at the top of the buffer
  assign w0    = blk_r[BLOCK_W-1      -: WORD_W];
  assign w2    = blk_r[BLOCK_W-1-2*32  -: WORD_W];
  assign w8    = blk_r[BLOCK_W-1-8*32  -: WORD_W];
  assign w13   = blk_r[BLOCK_W-1-13*32 -: WORD_W];
  assign w_mix = w13 ^ w8 ^ w2 ^ w0;
  assign w_new = {w_mix[30:0], w_mix[31]};

  sha1sh_round u_round (
    .a     (a_r),
    .b     (b_r),
    .c     (c_r),
    .d     (d_r),
    .e     (e_r),
    .w     (w0),
    .round (ctl.round),
    .t     (t)
  );

  always_ff @(posedge clk) begin
    if (ctl.shift_byte) begin
      blk_r <= {blk_r[BLOCK_W-9:0], ctl.byte_val};
    end else if (ctl.step) begin
      blk_r <= {blk_r[BLOCK_W-WORD_W-1:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_work) begin
      a_r <= h_r[0];
      b_r <= h_r[1];
      c_r <= h_r[2];
      d_r <= h_r[3];
      e_r <= h_r[4];
    end else if (ctl.step) begin
      a_r <= t;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.init_chain) begin
      h_r[0] <= IV0;
      h_r[1] <= IV1;
      h_r[2] <= IV2;
      h_r[3] <= IV3;
      h_r[4] <= IV4;
    end else if (ctl.add_chain) begin
      h_r[0] <= h_r[0] + a_r;
      h_r[1] <= h_r[1] + b_r;
      h_r[2] <= h_r[2] + c_r;
      h_r[3] <= h_r[3] + d_r;
      h_r[4] <= h_r[4] + e_r;
    end
  end

  assign chain = h_r;

endmodule

>>> rtl/sha1_stream_hasher_top.sv
// ----------------------------------------------------------------------------
// sha1_stream_hasher_top
// Streaming SHA-1: one message byte per input transfer, one digest per
// message on the output channel.
// ----------------------------------------------------------------------------
// The transfer that completes a 64-byte block makes the hasher busy for
// 80 rounds through the single shared round unit, then an add into the
// chaining words; no byte is taken meanwhile. On a transfer with last set,
// padding is pushed one byte per cycle, paused while a full block is
// compressed, until the block holds 64 bytes, with one or two block
// compressions; the digest then moves to the output register. The digest
// waits in its output register while the next message streams in; a finish
// stalls only if the previous digest is still untaken.
module sha1_stream_hasher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word0,
  output logic [31:0] out_digest_word1,
  output logic [31:0] out_digest_word2,
  output logic [31:0] out_digest_word3,
  output logic [31:0] out_digest_word4
);
  import sha1sh_pkg::*;

  state_t                state_r, state_nxt;
  logic [FILL_W-1:0]     fill_r, fill_nxt;
  logic [LEN_W-1:0]      bitlen_r, bitlen_nxt;
  logic [ROUND_W-1:0]    round_r, round_nxt;
  logic                  pend_last_r, pend_last_nxt;
  logic                  pad_mark_r, pad_mark_nxt;
  logic [LEN_CNT_W-1:0]  len_cnt_r, len_cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  chain_t                digest_r;
  logic                  load_out;

  ctl_t                  ctl;
  chain_t                chain;

  logic                  len_active;
  logic [LEN_W-1:0]      len_shifted;
  logic [7:0]            pad_byte;

  sha1sh_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .chain (chain)
  );

  // length bytes go out most significant first
  assign len_active  = (len_cnt_r != '0) || (fill_r == FILL_LEN);
  assign len_shifted = bitlen_r << {len_cnt_r[2:0], 3'b000};

  always_comb begin
    priority if (pad_mark_r) begin
      pad_byte = PAD_MARK;
    end else if (len_active) begin
      pad_byte = len_shifted[LEN_W-1 -: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    bitlen_nxt     = bitlen_r;
    round_nxt      = round_r;
    pend_last_nxt  = pend_last_r;
    pad_mark_nxt   = pad_mark_r;
    len_cnt_nxt    = len_cnt_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    load_out       = 1'b0;
    in_ready       = 1'b0;
    ctl            = '0;
    ctl.byte_val   = in_data_byte;
    ctl.round      = round_r;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          pend_last_nxt = in_last;
          pad_mark_nxt  = 1'b1;
          len_cnt_nxt   = '0;
          if (in_has_byte) begin
            ctl.shift_byte = 1'b1;
            fill_nxt       = fill_r + 1'b1;
            bitlen_nxt     = bitlen_r + 64'd8;
          end
          if (in_has_byte && fill_r == FILL_FULL) begin
            ctl.load_work = 1'b1;
            round_nxt     = '0;
            state_nxt     = ST_ROUND;
          end else if (in_last) begin
            state_nxt = ST_PAD;
          end
        end
      end

      ST_ROUND: begin
        ctl.step  = 1'b1;
        round_nxt = round_r + 1'b1;
        if (round_r == LAST_ROUND) begin
          state_nxt = ST_ADD;
        end
      end

      ST_ADD: begin
        ctl.add_chain = 1'b1;
        priority if (len_cnt_r == LEN_BYTES) begin
          state_nxt = ST_DONE;
        end else if (pend_last_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_PAD: begin
        ctl.shift_byte = 1'b1;
        ctl.byte_val   = pad_byte;
        fill_nxt       = fill_r + 1'b1;
        pad_mark_nxt   = 1'b0;
        if (!pad_mark_r && len_active) begin
          len_cnt_nxt = len_cnt_r + 1'b1;
        end
        if (fill_r == FILL_FULL) begin
          ctl.load_work = 1'b1;
          round_nxt     = '0;
          state_nxt     = ST_ROUND;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out       = 1'b1;
          out_valid_nxt  = 1'b1;
          ctl.init_chain = 1'b1;
          bitlen_nxt     = '0;
          pend_last_nxt  = 1'b0;
          len_cnt_nxt    = '0;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      bitlen_r    <= '0;
      round_r     <= '0;
      pend_last_r <= 1'b0;
      pad_mark_r  <= 1'b0;
      len_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      bitlen_r    <= bitlen_nxt;
      round_r     <= round_nxt;
      pend_last_r <= pend_last_nxt;
      pad_mark_r  <= pad_mark_nxt;
      len_cnt_r   <= len_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      digest_r <= chain;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_digest_word0 = digest_r[0];
  assign out_digest_word1 = digest_r[1];
  assign out_digest_word2 = digest_r[2];
  assign out_digest_word3 = digest_r[3];
  assign out_digest_word4 = digest_r[4];

endmodule
